[hdl/scc_pkg.sv]
// Shared constants, command and status types for the semispace collector
`timescale 1ns / 1ps
package scc_pkg;

  // Heap and stack geometry
  localparam int HALF_CELLS = 1024;
  localparam int ROOT_DEPTH = 256;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W   = $clog2(HALF_CELLS);
  localparam int CELL_AW = IDX_W + 1;
  localparam int CELLS   = 2 * HALF_CELLS;
  localparam int CNT_W   = $clog2(HALF_CELLS + 1);
  localparam int RA_W    = $clog2(ROOT_DEPTH);
  localparam int RC_W    = $clog2(ROOT_DEPTH + 1);
  localparam int VW      = VALUE_BITS + 1;

  // Port widths fixed by the interface
  localparam int KIND_W = 3;
  localparam int ARG_W  = 32;
  localparam int STAT_W = 3;
  localparam int LIVE_W = 11;

  // Operation kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FORCE = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_HEAP_FULL   = 3'd1;
  localparam logic [STAT_W-1:0] ST_STACK_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_STACK_EMPTY = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX   = 3'd4;

  // Datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_ERR,
    DP_PUSH,
    DP_ROOT_RD,
    DP_POP,
    DP_CELL_RD,
    DP_READ,
    DP_ALLOC,
    DP_GC_INIT,
    DP_GC_ROOT_RD,
    DP_GC_ROOT_LD,
    DP_GC_ROOT_WB,
    DP_VA_LD,
    DP_VA_WB,
    DP_VB_LD,
    DP_VB_WB,
    DP_FWD_RD,
    DP_FWD_EVAL,
    DP_FWD_SET,
    DP_SCAN_RD,
    DP_SCAN_LD,
    DP_SCAN_WB1,
    DP_SCAN_WB2,
    DP_GC_FLIP,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [STAT_W-1:0]   err;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              va_bad;
    logic              vb_bad;
    logic              used_full;
    logic              rc_full;
    logic              rc_empty;
    logic              idx_bad;
    logic              ri_zero;
    logic              fv_live;
    logic              mark;
    logic              nfi_full;
    logic              scan_more;
  } dp_stat_t;

  // A tagged value that names a cell below the fill level
  function automatic logic points_live(input logic [VW-1:0] v,
                                       input logic [CNT_W-1:0] used);
    return v[VALUE_BITS] && (v[VALUE_BITS-1:0] < VALUE_BITS'(used));
  endfunction

endpackage

[hdl/scc_datapath.sv]
// Heap memories, root stack, collector registers and result registers
`timescale 1ns / 1ps
module scc_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [scc_pkg::KIND_W-1:0]      in_kind,
  input  logic [scc_pkg::ARG_W-1:0]       in_arg_a,
  input  logic                            in_a_is_ptr,
  input  logic [scc_pkg::ARG_W-1:0]       in_arg_b,
  input  logic                            in_b_is_ptr,
  input  logic                            in_read_second,
  input  scc_pkg::dp_cmd_t                cmd,
  output scc_pkg::dp_stat_t               stat,
  output logic [scc_pkg::ARG_W-1:0]       out_value,
  output logic                            out_value_is_ptr,
  output logic [scc_pkg::STAT_W-1:0]      out_status,
  output logic                            out_collected,
  output logic [scc_pkg::LIVE_W-1:0]      out_live_cells
);

  // Memories
  logic [scc_pkg::VW-1:0] first_mem  [0:scc_pkg::CELLS-1];
  logic [scc_pkg::VW-1:0] second_mem [0:scc_pkg::CELLS-1];
  logic                   mark_mem   [0:scc_pkg::CELLS-1];
  logic [scc_pkg::VW-1:0] root_mem   [0:scc_pkg::ROOT_DEPTH-1];

  logic [scc_pkg::VW-1:0] first_q, second_q, root_q;
  logic                   mark_q;

  // Control registers
  logic                         active_r;
  logic [scc_pkg::CNT_W-1:0]    used_r, nfi_r, scan_r;
  logic [scc_pkg::RC_W-1:0]     rc_r, ri_r;

  // Item and work registers
  logic [scc_pkg::KIND_W-1:0]   kind_r;
  logic [scc_pkg::VW-1:0]       va_r, vb_r, fv_r, sec_r, res_r;
  logic [scc_pkg::ARG_W-1:0]    idx_r;
  logic                         rsel_r;
  logic [scc_pkg::STAT_W-1:0]   code_r;
  logic                         coll_r;

  // Output registers
  logic [scc_pkg::VW-1:0]       o_res_r;
  logic [scc_pkg::STAT_W-1:0]   o_code_r;
  logic                         o_coll_r;
  logic [scc_pkg::CNT_W-1:0]    o_live_r;

  // Addresses
  logic [scc_pkg::CELL_AW-1:0]  src_addr, dst_addr, scan_addr, rd_addr, alloc_addr;
  logic [scc_pkg::VW-1:0]       fwd_val;
  logic [scc_pkg::RC_W-1:0]     rc_m1, ri_m1;

  assign src_addr   = {active_r, fv_r[scc_pkg::IDX_W-1:0]};
  assign dst_addr   = {~active_r, nfi_r[scc_pkg::IDX_W-1:0]};
  assign scan_addr  = {~active_r, scan_r[scc_pkg::IDX_W-1:0]};
  assign rd_addr    = {active_r, idx_r[scc_pkg::IDX_W-1:0]};
  assign alloc_addr = {active_r, used_r[scc_pkg::IDX_W-1:0]};
  assign fwd_val    = {1'b1, scc_pkg::VALUE_BITS'(nfi_r)};
  assign rc_m1      = rc_r - scc_pkg::RC_W'(1);
  assign ri_m1      = ri_r - scc_pkg::RC_W'(1);

  // Port decode
  logic                         cell_re, root_re;
  logic [scc_pkg::CELL_AW-1:0]  cell_raddr;
  logic [scc_pkg::RA_W-1:0]     root_raddr, root_waddr;
  logic                         first_we, second_we, mark_we, root_we;
  logic [scc_pkg::CELL_AW-1:0]  first_waddr, second_waddr, mark_waddr;
  logic [scc_pkg::VW-1:0]       first_wdata, second_wdata, root_wdata;
  logic                         mark_wdata;

  always_comb begin
    cell_re      = 1'b0;
    cell_raddr   = src_addr;
    root_re      = 1'b0;
    root_raddr   = rc_m1[scc_pkg::RA_W-1:0];
    first_we     = 1'b0;
    first_waddr  = dst_addr;
    first_wdata  = first_q;
    second_we    = 1'b0;
    second_waddr = dst_addr;
    second_wdata = second_q;
    mark_we      = 1'b0;
    mark_waddr   = dst_addr;
    mark_wdata   = 1'b0;
    root_we      = 1'b0;
    root_waddr   = rc_r[scc_pkg::RA_W-1:0];
    root_wdata   = va_r;
    unique case (cmd.op)
      scc_pkg::DP_FWD_RD: begin
        cell_re    = 1'b1;
        cell_raddr = src_addr;
      end
      scc_pkg::DP_SCAN_RD: begin
        cell_re    = 1'b1;
        cell_raddr = scan_addr;
      end
      scc_pkg::DP_CELL_RD: begin
        cell_re    = 1'b1;
        cell_raddr = rd_addr;
      end
      scc_pkg::DP_ROOT_RD: begin
        root_re    = 1'b1;
        root_raddr = rc_m1[scc_pkg::RA_W-1:0];
      end
      scc_pkg::DP_GC_ROOT_RD: begin
        root_re    = 1'b1;
        root_raddr = ri_m1[scc_pkg::RA_W-1:0];
      end
      scc_pkg::DP_PUSH: begin
        root_we    = 1'b1;
        root_waddr = rc_r[scc_pkg::RA_W-1:0];
        root_wdata = va_r;
      end
      scc_pkg::DP_GC_ROOT_WB: begin
        root_we    = 1'b1;
        root_waddr = ri_r[scc_pkg::RA_W-1:0];
        root_wdata = fv_r;
      end
      // copy an unforwarded cell to the next free slot of the other half
      scc_pkg::DP_FWD_EVAL: begin
        if (!mark_q && !stat.nfi_full) begin
          first_we  = 1'b1;
          second_we = 1'b1;
          mark_we   = 1'b1;
        end
      end
      // leave the new index behind in the old cell
      scc_pkg::DP_FWD_SET: begin
        first_we    = 1'b1;
        first_waddr = src_addr;
        first_wdata = fwd_val;
        mark_we     = 1'b1;
        mark_waddr  = src_addr;
        mark_wdata  = 1'b1;
      end
      scc_pkg::DP_SCAN_WB1: begin
        first_we    = 1'b1;
        first_waddr = scan_addr;
        first_wdata = fv_r;
      end
      scc_pkg::DP_SCAN_WB2: begin
        second_we    = 1'b1;
        second_waddr = scan_addr;
        second_wdata = fv_r;
      end
      scc_pkg::DP_ALLOC: begin
        first_we     = 1'b1;
        first_waddr  = alloc_addr;
        first_wdata  = va_r;
        second_we    = 1'b1;
        second_waddr = alloc_addr;
        second_wdata = vb_r;
        mark_we      = 1'b1;
        mark_waddr   = alloc_addr;
        mark_wdata   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (first_we) first_mem[first_waddr] <= first_wdata;
    if (second_we) second_mem[second_waddr] <= second_wdata;
    if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
    if (root_we) root_mem[root_waddr] <= root_wdata;
    if (cell_re) begin
      first_q  <= first_mem[cell_raddr];
      second_q <= second_mem[cell_raddr];
      mark_q   <= mark_mem[cell_raddr];
    end
    if (root_re) root_q <= root_mem[root_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      used_r   <= '0;
      nfi_r    <= '0;
      scan_r   <= '0;
      rc_r     <= '0;
      ri_r     <= '0;
    end else begin
      unique case (cmd.op)
        scc_pkg::DP_GC_INIT: begin
          nfi_r  <= '0;
          scan_r <= '0;
          ri_r   <= rc_r;
        end
        scc_pkg::DP_GC_ROOT_RD: ri_r <= ri_m1;
        scc_pkg::DP_PUSH:       rc_r <= rc_r + scc_pkg::RC_W'(1);
        scc_pkg::DP_POP:        rc_r <= rc_m1;
        scc_pkg::DP_ALLOC: begin
          used_r <= used_r + scc_pkg::CNT_W'(1);
          nfi_r  <= used_r + scc_pkg::CNT_W'(1);
        end
        scc_pkg::DP_FWD_SET:  nfi_r  <= nfi_r + scc_pkg::CNT_W'(1);
        scc_pkg::DP_SCAN_WB2: scan_r <= scan_r + scc_pkg::CNT_W'(1);
        scc_pkg::DP_GC_FLIP: begin
          used_r   <= nfi_r;
          active_r <= ~active_r;
        end
        default: begin
        end
      endcase
    end
  end

  // Item, work and output registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      scc_pkg::DP_LOAD: begin
        kind_r <= in_kind;
        va_r   <= {in_a_is_ptr, in_arg_a[scc_pkg::VALUE_BITS-1:0]};
        vb_r   <= {in_b_is_ptr, in_arg_b[scc_pkg::VALUE_BITS-1:0]};
        idx_r  <= in_arg_a;
        rsel_r <= in_read_second;
        res_r  <= '0;
        code_r <= scc_pkg::ST_OK;
        coll_r <= 1'b0;
      end
      scc_pkg::DP_ERR:        code_r <= cmd.err;
      scc_pkg::DP_POP:        res_r  <= root_q;
      scc_pkg::DP_READ:       res_r  <= rsel_r ? second_q : first_q;
      scc_pkg::DP_ALLOC:      res_r  <= {1'b1, scc_pkg::VALUE_BITS'(used_r)};
      scc_pkg::DP_GC_ROOT_LD: fv_r   <= root_q;
      scc_pkg::DP_VA_LD:      fv_r   <= va_r;
      scc_pkg::DP_VA_WB:      va_r   <= fv_r;
      scc_pkg::DP_VB_LD:      fv_r   <= vb_r;
      scc_pkg::DP_VB_WB:      vb_r   <= fv_r;
      scc_pkg::DP_FWD_EVAL: begin
        if (mark_q) fv_r <= first_q;
      end
      scc_pkg::DP_FWD_SET:    fv_r   <= fwd_val;
      scc_pkg::DP_SCAN_LD: begin
        fv_r  <= first_q;
        sec_r <= second_q;
      end
      scc_pkg::DP_SCAN_WB1:   fv_r   <= sec_r;
      scc_pkg::DP_GC_FLIP:    coll_r <= 1'b1;
      scc_pkg::DP_EMIT: begin
        o_res_r  <= res_r;
        o_code_r <= code_r;
        o_coll_r <= coll_r;
        o_live_r <= used_r;
      end
      default: begin
      end
    endcase
  end

  // Status toward the controller
  always_comb begin
    stat.kind      = kind_r;
    stat.va_bad    = va_r[scc_pkg::VALUE_BITS] && !scc_pkg::points_live(va_r, used_r);
    stat.vb_bad    = vb_r[scc_pkg::VALUE_BITS] && !scc_pkg::points_live(vb_r, used_r);
    stat.used_full = used_r >= scc_pkg::CNT_W'(scc_pkg::HALF_CELLS);
    stat.rc_full   = rc_r == scc_pkg::RC_W'(scc_pkg::ROOT_DEPTH);
    stat.rc_empty  = rc_r == '0;
    stat.idx_bad   = idx_r >= scc_pkg::ARG_W'(used_r);
    stat.ri_zero   = ri_r == '0;
    stat.fv_live   = scc_pkg::points_live(fv_r, used_r);
    stat.mark      = mark_q;
    stat.nfi_full  = nfi_r >= scc_pkg::CNT_W'(scc_pkg::HALF_CELLS);
    stat.scan_more = scan_r < nfi_r;
  end

  assign out_value        = scc_pkg::ARG_W'(o_res_r[scc_pkg::VALUE_BITS-1:0]);
  assign out_value_is_ptr = o_res_r[scc_pkg::VALUE_BITS];
  assign out_status       = o_code_r;
  assign out_collected    = o_coll_r;
  assign out_live_cells   = scc_pkg::LIVE_W'(o_live_r);

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= scc_pkg::CNT_W'(scc_pkg::HALF_CELLS))
    else $error("fill level beyond half size");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r <= scc_pkg::RC_W'(scc_pkg::ROOT_DEPTH))
    else $error("root count beyond stack depth");

  a_scan_behind: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r <= nfi_r)
    else $error("scan pointer passed free pointer");

  a_flip_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == scc_pkg::DP_GC_FLIP |=> used_r == $past(nfi_r))
    else $error("fill level not taken from copy count at flip");
`endif

endmodule

[hdl/scc_ctrl.sv]
// Sequencer for item dispatch and the breadth-first collection
`timescale 1ns / 1ps
module scc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  scc_pkg::dp_stat_t  stat,
  output scc_pkg::dp_cmd_t   cmd
);

  typedef enum logic [20:0] {
    S_IDLE       = 21'h000001,
    S_DISP       = 21'h000002,
    S_ALLOC      = 21'h000004,
    S_POP        = 21'h000008,
    S_READ       = 21'h000010,
    S_DONE       = 21'h000020,
    S_GC_INIT    = 21'h000040,
    S_GC_ROOT    = 21'h000080,
    S_GC_ROOT_LD = 21'h000100,
    S_GC_ROOT_WB = 21'h000200,
    S_GC_VA      = 21'h000400,
    S_GC_VA_WB   = 21'h000800,
    S_GC_VB      = 21'h001000,
    S_GC_VB_WB   = 21'h002000,
    S_GC_SCAN    = 21'h004000,
    S_SCAN_LD    = 21'h008000,
    S_SCAN_WB1   = 21'h010000,
    S_SCAN_WB2   = 21'h020000,
    S_FWD_CHK    = 21'h040000,
    S_FWD_EVAL   = 21'h080000,
    S_FWD_SET    = 21'h100000
  } state_t;

  typedef enum logic [2:0] {
    RET_ROOT,
    RET_VA,
    RET_VB,
    RET_S1,
    RET_S2
  } ret_t;

  state_t state_r, state_nxt;
  ret_t   ret_r, ret_nxt;
  logic   out_valid_r, out_valid_nxt;
  state_t ret_state;
  logic   is_alloc;

  assign is_alloc = stat.kind == scc_pkg::KIND_ALLOC;

  // Where a finished forward hands control back
  always_comb begin
    unique case (ret_r)
      RET_ROOT: ret_state = S_GC_ROOT_WB;
      RET_VA:   ret_state = S_GC_VA_WB;
      RET_VB:   ret_state = S_GC_VB_WB;
      RET_S1:   ret_state = S_SCAN_WB1;
      RET_S2:   ret_state = S_SCAN_WB2;
      default:  ret_state = S_IDLE;
    endcase
  end

  // Next state and command
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = scc_pkg::DP_NOP;
    cmd.err       = scc_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = scc_pkg::DP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority if (stat.kind == scc_pkg::KIND_ALLOC) begin
          priority if (stat.va_bad || stat.vb_bad) begin
            cmd.op    = scc_pkg::DP_ERR;
            cmd.err   = scc_pkg::ST_BAD_INDEX;
            state_nxt = S_DONE;
          end else if (stat.used_full) begin
            state_nxt = S_GC_INIT;
          end else begin
            state_nxt = S_ALLOC;
          end
        end else if (stat.kind == scc_pkg::KIND_PUSH) begin
          priority if (stat.va_bad) begin
            cmd.op  = scc_pkg::DP_ERR;
            cmd.err = scc_pkg::ST_BAD_INDEX;
          end else if (stat.rc_full) begin
            cmd.op  = scc_pkg::DP_ERR;
            cmd.err = scc_pkg::ST_STACK_FULL;
          end else begin
            cmd.op  = scc_pkg::DP_PUSH;
          end
          state_nxt = S_DONE;
        end else if (stat.kind == scc_pkg::KIND_POP) begin
          if (stat.rc_empty) begin
            cmd.op    = scc_pkg::DP_ERR;
            cmd.err   = scc_pkg::ST_STACK_EMPTY;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = scc_pkg::DP_ROOT_RD;
            state_nxt = S_POP;
          end
        end else if (stat.kind == scc_pkg::KIND_READ) begin
          if (stat.idx_bad) begin
            cmd.op    = scc_pkg::DP_ERR;
            cmd.err   = scc_pkg::ST_BAD_INDEX;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = scc_pkg::DP_CELL_RD;
            state_nxt = S_READ;
          end
        end else if (stat.kind == scc_pkg::KIND_FORCE) begin
          state_nxt = S_GC_INIT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // allocate, or report a heap still full after collection
      S_ALLOC: begin
        if (stat.used_full) begin
          cmd.op  = scc_pkg::DP_ERR;
          cmd.err = scc_pkg::ST_HEAP_FULL;
        end else begin
          cmd.op  = scc_pkg::DP_ALLOC;
        end
        state_nxt = S_DONE;
      end
      S_POP: begin
        cmd.op    = scc_pkg::DP_POP;
        state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.op    = scc_pkg::DP_READ;
        state_nxt = S_DONE;
      end
      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = scc_pkg::DP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_GC_INIT: begin
        cmd.op    = scc_pkg::DP_GC_INIT;
        state_nxt = S_GC_ROOT;
      end
      // walk the roots from the top of the stack down
      S_GC_ROOT: begin
        if (stat.ri_zero) begin
          state_nxt = is_alloc ? S_GC_VA : S_GC_SCAN;
        end else begin
          cmd.op    = scc_pkg::DP_GC_ROOT_RD;
          state_nxt = S_GC_ROOT_LD;
        end
      end
      S_GC_ROOT_LD: begin
        cmd.op    = scc_pkg::DP_GC_ROOT_LD;
        ret_nxt   = RET_ROOT;
        state_nxt = S_FWD_CHK;
      end
      S_GC_ROOT_WB: begin
        cmd.op    = scc_pkg::DP_GC_ROOT_WB;
        state_nxt = S_GC_ROOT;
      end
      // alloc operands act as temporary roots
      S_GC_VA: begin
        cmd.op    = scc_pkg::DP_VA_LD;
        ret_nxt   = RET_VA;
        state_nxt = S_FWD_CHK;
      end
      S_GC_VA_WB: begin
        cmd.op    = scc_pkg::DP_VA_WB;
        state_nxt = S_GC_VB;
      end
      S_GC_VB: begin
        cmd.op    = scc_pkg::DP_VB_LD;
        ret_nxt   = RET_VB;
        state_nxt = S_FWD_CHK;
      end
      S_GC_VB_WB: begin
        cmd.op    = scc_pkg::DP_VB_WB;
        state_nxt = S_GC_SCAN;
      end
      // scan copied cells until the scan pointer meets the free pointer
      S_GC_SCAN: begin
        if (stat.scan_more) begin
          cmd.op    = scc_pkg::DP_SCAN_RD;
          state_nxt = S_SCAN_LD;
        end else begin
          cmd.op    = scc_pkg::DP_GC_FLIP;
          state_nxt = is_alloc ? S_ALLOC : S_DONE;
        end
      end
      S_SCAN_LD: begin
        cmd.op    = scc_pkg::DP_SCAN_LD;
        ret_nxt   = RET_S1;
        state_nxt = S_FWD_CHK;
      end
      S_SCAN_WB1: begin
        cmd.op    = scc_pkg::DP_SCAN_WB1;
        ret_nxt   = RET_S2;
        state_nxt = S_FWD_CHK;
      end
      S_SCAN_WB2: begin
        cmd.op    = scc_pkg::DP_SCAN_WB2;
        state_nxt = S_GC_SCAN;
      end
      // forward one value: skip plain data, fetch the cell otherwise
      S_FWD_CHK: begin
        if (stat.fv_live) begin
          cmd.op    = scc_pkg::DP_FWD_RD;
          state_nxt = S_FWD_EVAL;
        end else begin
          state_nxt = ret_state;
        end
      end
      S_FWD_EVAL: begin
        cmd.op = scc_pkg::DP_FWD_EVAL;
        if (stat.mark || stat.nfi_full) begin
          state_nxt = ret_state;
        end else begin
          state_nxt = S_FWD_SET;
        end
      end
      S_FWD_SET: begin
        cmd.op    = scc_pkg::DP_FWD_SET;
        state_nxt = ret_state;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= RET_ROOT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == scc_pkg::DP_LOAD |=> state_r == S_DISP)
    else $error("load not followed by dispatch");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == scc_pkg::DP_EMIT |=> out_valid_r)
    else $error("result emitted without valid");

  a_fwd_eval_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FWD_EVAL |-> $past(cmd.op == scc_pkg::DP_FWD_RD))
    else $error("forward evaluated without cell fetch");
`endif

endmodule

[hdl/semispace_copying_collector_core.sv]
// Top level of the semispace copying collector
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | kind, arg_a, a_is_ptr, arg_b, b_is_ptr, read_second
//  out_    | output    | out_valid / out_stall | value, value_is_ptr, status, collected, live_cells
//
// One item at a time. A collection sets up, walks the roots and the alloc
// operands, forwards each value (plain, already moved, copied), scans each
// copied cell with forwards of its two fields and then flips halves; the
// pace of every step is set by the single read and write port of each cell
// memory.
// Reset is synchronous active low and clears counters, half select and FSM.
// The result register holds under out_stall while the next item proceeds.
`timescale 1ns / 1ps
module semispace_copying_collector_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [scc_pkg::KIND_W-1:0]      in_kind,
  input  logic [scc_pkg::ARG_W-1:0]       in_arg_a,
  input  logic                            in_a_is_ptr,
  input  logic [scc_pkg::ARG_W-1:0]       in_arg_b,
  input  logic                            in_b_is_ptr,
  input  logic                            in_read_second,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [scc_pkg::ARG_W-1:0]       out_value,
  output logic                            out_value_is_ptr,
  output logic [scc_pkg::STAT_W-1:0]      out_status,
  output logic                            out_collected,
  output logic [scc_pkg::LIVE_W-1:0]      out_live_cells
);

  scc_pkg::dp_cmd_t  cmd;
  scc_pkg::dp_stat_t stat;

  // Sequencer
  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Heap, stack and result datapath
  scc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_kind          (in_kind),
    .in_arg_a         (in_arg_a),
    .in_a_is_ptr      (in_a_is_ptr),
    .in_arg_b         (in_arg_b),
    .in_b_is_ptr      (in_b_is_ptr),
    .in_read_second   (in_read_second),
    .cmd              (cmd),
    .stat             (stat),
    .out_value        (out_value),
    .out_value_is_ptr (out_value_is_ptr),
    .out_status       (out_status),
    .out_collected    (out_collected),
    .out_live_cells   (out_live_cells)
  );

endmodule
